### hdl/ttp_pkg.sv
// Shared types and constants for the thermal throttle policy block.
// No dependencies; imported by thermal_throttle_policy.
`default_nettype none

package ttp_pkg;

   // Throttle mode codes
   typedef enum logic [1:0] {
      MODE_NORMAL   = 2'd0,
      MODE_LIGHT    = 2'd1,
      MODE_SEVERE   = 2'd2,
      MODE_SHUTDOWN = 2'd3
   } mode_type;

   // Policy stage codes
   typedef enum logic [1:0] {
      STAGE_OFF      = 2'd0,
      STAGE_READONLY = 2'd1,
      STAGE_SHADOW   = 2'd2,
      STAGE_ACTIVE   = 2'd3
   } stage_type;

   // Register indexes on the csr port
   localparam logic [2:0] REG_LIGHT_ON     = 3'd0;
   localparam logic [2:0] REG_LIGHT_OFF    = 3'd1;
   localparam logic [2:0] REG_SEVERE_ON    = 3'd2;
   localparam logic [2:0] REG_SEVERE_OFF   = 3'd3;
   localparam logic [2:0] REG_SHUTDOWN_ON  = 3'd4;
   localparam logic [2:0] REG_SHUTDOWN_OFF = 3'd5;
   localparam logic [2:0] REG_DEBOUNCE     = 3'd6;
   localparam logic [2:0] REG_STAGE        = 3'd7;

   // Field widths
   localparam int TEMP_W  = 16;
   localparam int CNT_W   = 16;
   localparam int GEN_W   = 32;
   localparam int SCALE_W = 16;
   localparam int CSR_W   = 16;
   localparam int RSP_W   = 88;

   localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
   localparam logic [SCALE_W-1:0] SCALE_ONE = 16'h8000;

   // One result item
   typedef struct packed {
      logic [1:0]         pad;
      logic [CNT_W-1:0]   dwell_samples;
      logic [CNT_W-1:0]   candidate_run;
      logic               mode_changed;
      logic [GEN_W-1:0]   generation;
      logic               admit_new;
      logic [SCALE_W-1:0] power_scale;
      mode_type           effective_mode;
      mode_type           tracked_mode;
   } result_type;

endpackage

`default_nettype wire

### hdl/thermal_throttle_policy.sv
// Thermal throttle policy: hysteresis mode tracking with dwell and debounce.
// Depends on ttp_pkg (mode, stage codes and result layout).
//
//   channel   dir  width  contents
//   req_*     in   16     max_temperature
//   rsp_*     out  88     tracked, effective mode, scale, admit, generation, ...
//   csr_*     in   3+16   register write, index 0..7
//
// One sample per cycle sustained while rsp_tready stays high; a sample passes the input
// register, then the policy update lands in the state and result registers together.
// Reset clears the mode state and loads the default thresholds.
// A stalled result holds in the output register; the input register keeps one
// more sample, after which req_tready drops until the result is taken.
`default_nettype none

module thermal_throttle_policy
   import ttp_pkg::*;
#(
   parameter int LIGHT_POWER_Q15 = 16384,
   parameter int MIN_DWELL       = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // csr write port
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_addr,
   input  wire logic [CSR_W-1:0]  csr_wdata,
   // sample stream
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [TEMP_W-1:0] req_tdata,   // [15:0] max_temperature
   // result stream
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata    // [1:0] tracked_mode, [3:2] effective_mode,
                                               // [19:4] power_scale, [20] admit_new,
                                               // [52:21] generation, [53] mode_changed,
                                               // [69:54] candidate_run, [85:70] dwell_samples
);

   localparam logic [SCALE_W-1:0] LIGHT_POWER = SCALE_W'(LIGHT_POWER_Q15);
   localparam logic [CNT_W-1:0]   DWELL_MIN   = CNT_W'(MIN_DWELL);

   // Configuration registers
   logic signed [TEMP_W-1:0] light_on_ff, light_off_ff, severe_on_ff, severe_off_ff;
   logic signed [TEMP_W-1:0] shut_on_ff, shut_off_ff;
   logic [CNT_W-1:0]         debounce_ff;
   stage_type                stage_ff;

   // Policy state
   mode_type             mode_ff, mode_in;
   mode_type             cand_mode_ff, cand_mode_in;
   logic [CNT_W-1:0]     cand_cnt_ff, cand_cnt_in;
   logic [CNT_W-1:0]     dwell_ff, dwell_in;
   logic [GEN_W-1:0]     gen_ff, gen_in;

   // Pipeline registers
   logic                     in_valid_ff;
   logic signed [TEMP_W-1:0] temp_ff;
   logic                     out_valid_ff;
   result_type               result_ff, result_in;

   logic      advance;
   logic      changed;
   mode_type  req_mode;
   mode_type  eff_mode;
   logic [CNT_W-1:0] dwell_inc;
   logic [CNT_W-1:0] cnt_step;

   // Move the held sample forward when the result slot is free or drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = result_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         light_on_ff   <= 16'sd1360;
         light_off_ff  <= 16'sd1200;
         severe_on_ff  <= 16'sd1520;
         severe_off_ff <= 16'sd1440;
         shut_on_ff    <= 16'sd1680;
         shut_off_ff   <= 16'sd1600;
         debounce_ff   <= 16'd1;
         stage_ff      <= STAGE_OFF;
      end else if (csr_we) begin
         case (csr_addr)
            REG_LIGHT_ON:     light_on_ff   <= csr_wdata;
            REG_LIGHT_OFF:    light_off_ff  <= csr_wdata;
            REG_SEVERE_ON:    severe_on_ff  <= csr_wdata;
            REG_SEVERE_OFF:   severe_off_ff <= csr_wdata;
            REG_SHUTDOWN_ON:  shut_on_ff    <= csr_wdata;
            REG_SHUTDOWN_OFF: shut_off_ff   <= csr_wdata;
            REG_DEBOUNCE:     debounce_ff   <= csr_wdata;
            REG_STAGE:        stage_ff      <= stage_type'(csr_wdata[1:0]);
            default:          ;
         endcase
      end
   end

   // Pick the requested mode from the held mode and the thresholds
   always_comb begin
      if (temp_ff >= shut_on_ff) begin
         req_mode = MODE_SHUTDOWN;
      end else begin
         case (mode_ff)
            MODE_NORMAL: begin
               if (temp_ff >= severe_on_ff)     req_mode = MODE_SEVERE;
               else if (temp_ff >= light_on_ff) req_mode = MODE_LIGHT;
               else                             req_mode = MODE_NORMAL;
            end
            MODE_LIGHT: begin
               if (temp_ff >= severe_on_ff)       req_mode = MODE_SEVERE;
               else if (temp_ff <= light_off_ff)  req_mode = MODE_NORMAL;
               else                               req_mode = MODE_LIGHT;
            end
            MODE_SEVERE: begin
               if (temp_ff <= severe_off_ff)
                  req_mode = (temp_ff <= light_off_ff) ? MODE_NORMAL : MODE_LIGHT;
               else
                  req_mode = MODE_SEVERE;
            end
            default: begin
               if (temp_ff > shut_off_ff)        req_mode = MODE_SHUTDOWN;
               else if (temp_ff >= severe_on_ff) req_mode = MODE_SEVERE;
               else if (temp_ff >= light_on_ff)  req_mode = MODE_LIGHT;
               else                              req_mode = MODE_NORMAL;
            end
         endcase
      end
   end

   // Update dwell, debounce run and mode
   always_comb begin
      dwell_inc    = (dwell_ff != CNT_MAX) ? dwell_ff + 1'b1 : dwell_ff;
      mode_in      = mode_ff;
      cand_mode_in = cand_mode_ff;
      cand_cnt_in  = cand_cnt_ff;
      dwell_in     = dwell_inc;
      gen_in       = gen_ff;
      changed      = 1'b0;
      cnt_step     = cand_cnt_ff;

      if (req_mode == mode_ff) begin
         cand_mode_in = mode_ff;
         cand_cnt_in  = '0;
      end else if (dwell_inc >= DWELL_MIN) begin
         if (req_mode != cand_mode_ff) begin
            cand_mode_in = req_mode;
            cnt_step     = CNT_W'(1);
         end else if (cand_cnt_ff != CNT_MAX) begin
            cnt_step = cand_cnt_ff + 1'b1;
         end
         cand_cnt_in = cnt_step;
         if (cnt_step >= debounce_ff) begin
            mode_in     = cand_mode_in;
            cand_cnt_in = '0;
            dwell_in    = '0;
            gen_in      = gen_ff + 1'b1;
            changed     = 1'b1;
         end
      end

      // Stage off or read only: fixed normal answer, state held
      if (stage_ff == STAGE_OFF || stage_ff == STAGE_READONLY) begin
         mode_in      = mode_ff;
         cand_mode_in = cand_mode_ff;
         cand_cnt_in  = cand_cnt_ff;
         dwell_in     = dwell_ff;
         gen_in       = gen_ff;
         changed      = 1'b0;
      end
   end

   // Build the result item
   always_comb begin
      eff_mode = (stage_ff == STAGE_ACTIVE) ? mode_in : MODE_NORMAL;
      result_in                = '0;
      result_in.tracked_mode   = mode_in;
      result_in.effective_mode = eff_mode;
      result_in.power_scale    = SCALE_ONE;
      result_in.admit_new      = 1'b1;
      result_in.generation     = gen_in;
      result_in.mode_changed   = changed;
      result_in.candidate_run  = cand_cnt_in;
      result_in.dwell_samples  = dwell_in;
      case (eff_mode)
         MODE_LIGHT:    result_in.power_scale = LIGHT_POWER;
         MODE_SEVERE:   result_in.admit_new = 1'b0;
         MODE_SHUTDOWN: begin
            result_in.power_scale = '0;
            result_in.admit_new   = 1'b0;
         end
         default:       ;
      endcase
      if (stage_ff == STAGE_OFF || stage_ff == STAGE_READONLY) begin
         result_in.tracked_mode  = MODE_NORMAL;
         result_in.candidate_run = '0;
         result_in.dwell_samples = '0;
      end
   end

   // Hold the sample and result handshakes
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready)
            in_valid_ff <= req_tvalid;
         if (advance)
            out_valid_ff <= 1'b1;
         else if (rsp_tready)
            out_valid_ff <= 1'b0;
      end
   end

   // Capture sample and result payloads
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready)
         temp_ff <= req_tdata;
      if (advance)
         result_ff <= result_in;
   end

   // Commit the policy state once per transfer through the update
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         cand_mode_ff <= MODE_NORMAL;
         cand_cnt_ff  <= '0;
         dwell_ff     <= '0;
         gen_ff       <= '0;
      end else if (advance) begin
         mode_ff      <= mode_in;
         cand_mode_ff <= cand_mode_in;
         cand_cnt_ff  <= cand_cnt_in;
         dwell_ff     <= dwell_in;
         gen_ff       <= gen_in;
      end
   end

   // A mode change restarts dwell and the debounce run
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result_ff.mode_changed |->
         result_ff.dwell_samples == '0 && result_ff.candidate_run == '0)
      else $error("mode change without dwell and run restart");

   // The generation steps by one on a taken change
   assert property (@(posedge clock) disable iff (reset)
      advance && changed |=> gen_ff == $past(gen_ff) + 1'b1)
      else $error("generation did not advance on mode change");

   // The state holds when no sample goes through the update
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(gen_ff) && $stable(mode_ff) && $stable(dwell_ff))
      else $error("policy state moved without a sample");

   // A non-normal effective mode is the tracked mode
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result_ff.effective_mode != MODE_NORMAL |->
         result_ff.effective_mode == result_ff.tracked_mode)
      else $error("effective mode differs from tracked mode");

endmodule

`default_nettype wire
